### sv/tas_pkg.sv
package tas_pkg;

   localparam int MAX_NODES_DEF = 64;

   // Request field widths.
   localparam int FUNC_W  = 3;
   localparam int NODE_W  = 6;
   localparam int STR_W   = 2;
   localparam int LIMIT_W = 7;

   // Result field widths.
   localparam int STATUS_W  = 2;
   localparam int DEGREE_W  = 7;
   localparam int CNT_OUT_W = 13;

   // Node count register and its square.
   localparam int NODES_W = 7;
   localparam int NSQ_W   = 14;

   localparam int LIST_CAP = 64;
   localparam int CNT_SAT  = 8191;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FN_READ     = 3'd0;
   localparam logic [FUNC_W-1:0] FN_WRITE    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_ROW_DEG  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_COL_DEG  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_ROW_LIST = 3'd4;
   localparam logic [FUNC_W-1:0] FN_COL_LIST = 3'd5;
   localparam logic [FUNC_W-1:0] FN_COUNTS   = 3'd6;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_STR = 2'd2;

   // Strength encodings (two's complement).
   localparam logic [STR_W-1:0] STR_NONE  = 2'b00;
   localparam logic [STR_W-1:0] STR_PLUS  = 2'b01;
   localparam logic [STR_W-1:0] STR_BAD   = 2'b10;
   localparam logic [STR_W-1:0] STR_MINUS = 2'b11;

   typedef struct packed {
      logic             en;
      logic [STR_W-1:0] old_s;
      logic [STR_W-1:0] new_s;
   } tally_upd_type;

   function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [31:0] v);
      logic [CNT_OUT_W-1:0] r;
      if (v > 32'(CNT_SAT)) begin
         r = CNT_OUT_W'(CNT_SAT);
      end else begin
         r = v[CNT_OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

### sv/tas_tally.sv
module tas_tally
   import tas_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tally_upd_type        upd,
   input  logic [NSQ_W-1:0]     nsq,
   output logic [CNT_OUT_W-1:0] exc_count,
   output logic [CNT_OUT_W-1:0] inh_count,
   output logic [CNT_OUT_W-1:0] empty_count
);

   localparam int CNT_W = $clog2(MAX_NODES * MAX_NODES + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int EW    = (SUM_W > NSQ_W) ? SUM_W : NSQ_W;

   logic [CNT_W-1:0] plus_ff, plus_in;
   logic [CNT_W-1:0] minus_ff, minus_in;
   logic [EW-1:0]    used;
   logic [EW-1:0]    nsq_x;
   logic [EW-1:0]    empty;

   // The outputs show the counts as they stand after this cycle's update.
   always_comb begin
      plus_in  = plus_ff;
      minus_in = minus_ff;
      if (upd.en) begin
         if (upd.old_s == STR_PLUS) begin
            plus_in = plus_in - CNT_W'(1);
         end else if (upd.old_s == STR_MINUS) begin
            minus_in = minus_in - CNT_W'(1);
         end
         if (upd.new_s == STR_PLUS) begin
            plus_in = plus_in + CNT_W'(1);
         end else if (upd.new_s == STR_MINUS) begin
            minus_in = minus_in + CNT_W'(1);
         end
      end
   end

   always_comb begin
      used  = EW'(plus_in) + EW'(minus_in);
      nsq_x = EW'(nsq);
      empty = (nsq_x > used) ? (nsq_x - used) : '0;
   end

   assign exc_count   = sat_count(32'(plus_in));
   assign inh_count   = sat_count(32'(minus_in));
   assign empty_count = sat_count(32'(empty));

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_ff  <= '0;
         minus_ff <= '0;
      end else begin
         plus_ff  <= plus_in;
         minus_ff <= minus_in;
      end
   end

endmodule

### sv/ternary_adjacency_store_core.sv
// Channel   Direction  Handshake                   Payload
// req_      in         req_tvalid / req_tready     tdata: from_node, to_node, new_strength,
//                                                  list_limit; tuser: func
// rsp_      out        rsp_tvalid / rsp_tready     tdata: status .. empty_count;
//                                                  tuser: found; tlast: last
// csr_      in         csr_valid / csr_ready       csr_data: node_count
//
// Read, write, counts and any request that fails its checks issue the single matrix
// memory read with the accept, then finish in the execute state (write back and tally update).
// A degree request makes one pass over the n entries of its row or column and a list two
// at most, where n is the node count: one pass counts, a second stops at the last entry
// listed. Both passes share the one memory read port.
// After reset a clearing pass writes zero to every memory entry, one entry a cycle;
// no item is accepted during it, configuration is.
// A stalled result holds in the output register; the block waits until it is free.

module ternary_adjacency_store_core
   import tas_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // [5:0] from_node, [11:6] to_node, [13:12] new_strength, [20:14] list_limit,
   // [23:21] zero
   input  logic [23:0]  req_tdata,
   // [2:0] func
   input  logic [2:0]   req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] status, [3:2] strength_out, [9:4] node_index, [16:10] degree,
   // [29:17] excitatory_count, [42:30] inhibitory_count, [55:43] empty_count
   output logic [55:0]  rsp_tdata,
   // [0] found
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tlast,

   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_data
);

   localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int DEPTH     = 1 << ADDR_W;
   localparam int CW        = (IDX_W > NODES_W) ? IDX_W : NODES_W;
   localparam int NODES_RST = (MAX_NODES < 64) ? MAX_NODES : 64;
   localparam int NSQ_RST   = NODES_RST * NODES_RST;

   // Sequencer state codes.
   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_LIST = 3'd4;

   // Request fields.
   logic [FUNC_W-1:0]  req_func;
   logic [NODE_W-1:0]  req_from;
   logic [NODE_W-1:0]  req_to;
   logic [STR_W-1:0]   req_str;
   logic [LIMIT_W-1:0] req_limit;

   assign req_func  = req_tuser;
   assign req_from  = req_tdata[5:0];
   assign req_to    = req_tdata[11:6];
   assign req_str   = req_tdata[13:12];
   assign req_limit = req_tdata[20:14];

   // Configuration: the clamped node count and its square are kept together.
   logic [NODES_W-1:0] nodes_ff;
   logic [NSQ_W-1:0]   nsq_ff;
   logic [NODES_W-1:0] csr_nodes;

   assign csr_ready = 1'b1;
   assign csr_nodes = (int'(csr_data) > MAX_NODES) ? NODES_W'(MAX_NODES) : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff <= NODES_W'(NODES_RST);
         nsq_ff   <= NSQ_W'(NSQ_RST);
      end else if (csr_valid) begin
         nodes_ff <= csr_nodes;
         nsq_ff   <= NSQ_W'({7'b0, csr_nodes} * {7'b0, csr_nodes});
      end
   end

   // Matrix memory: one write port, one read port, registered read data.
   logic [STR_W-1:0]  mem [DEPTH];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [STR_W-1:0]  mem_wd;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_ra;
   logic [STR_W-1:0]  mem_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   // Sequencer and request registers.
   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [NODE_W-1:0]  from_ff, from_in;
   logic [NODE_W-1:0]  to_ff, to_in;
   logic [STR_W-1:0]   str_ff, str_in;
   logic [LIMIT_W-1:0] cap_ff, cap_in;
   logic               bad_ff, bad_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [DEGREE_W-1:0] cnt_ff, cnt_in;
   logic [DEGREE_W-1:0] k_ff, k_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  o_status_ff, o_status_in;
   logic [STR_W-1:0]     o_str_ff, o_str_in;
   logic [NODE_W-1:0]    o_idx_ff, o_idx_in;
   logic                 o_found_ff, o_found_in;
   logic [DEGREE_W-1:0]  o_deg_ff, o_deg_in;
   logic [CNT_OUT_W-1:0] o_exc_ff, o_inh_ff, o_emp_ff;
   logic                 o_last_ff, o_last_in;
   logic                 out_load;
   logic                 out_free;

   tally_upd_type        upd;
   logic [CNT_OUT_W-1:0] exc_count, inh_count, empty_count;

   tas_tally #(
      .MAX_NODES (MAX_NODES)
   ) u_tally (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .nsq         (nsq_ff),
      .exc_count   (exc_count),
      .inh_count   (inh_count),
      .empty_count (empty_count)
   );

   // Scan helpers.
   logic                scan_row;
   logic [IDX_W-1:0]    from_i;
   logic [IDX_W-1:0]    j_next;
   logic                j_last;
   logic                entry_nz;
   logic [DEGREE_W-1:0] tot;
   logic [DEGREE_W-1:0] list_n;
   logic                req_bad_row;
   logic                req_bad_col;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign scan_row = (func_ff == FN_ROW_DEG) || (func_ff == FN_ROW_LIST);
   assign from_i   = IDX_W'(from_ff);
   assign j_next   = j_ff + IDX_W'(1);
   assign j_last   = (CW'(j_ff) == CW'(NODES_W'(nodes_ff - NODES_W'(1))));
   assign entry_nz = (mem_rd_ff != STR_NONE);
   assign tot      = cnt_ff + DEGREE_W'(entry_nz);
   assign list_n   = (tot > DEGREE_W'(cap_ff)) ? DEGREE_W'(cap_ff) : tot;

   assign req_bad_row = ({1'b0, req_from} >= nodes_ff);
   assign req_bad_col = ({1'b0, req_to} >= nodes_ff);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      func_in  = func_ff;
      from_in  = from_ff;
      to_in    = to_ff;
      str_in   = str_ff;
      cap_in   = cap_ff;
      bad_in   = bad_ff;
      j_in     = j_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;

      mem_we = 1'b0;
      mem_wa = {from_i, IDX_W'(to_ff)};
      mem_wd = str_ff;
      mem_re = 1'b0;
      mem_ra = scan_row ? {from_i, j_next} : {j_next, from_i};

      upd.en    = 1'b0;
      upd.old_s = mem_rd_ff;
      upd.new_s = str_ff;

      out_load    = 1'b0;
      o_status_in = ST_OK;
      o_str_in    = STR_NONE;
      o_idx_in    = '0;
      o_found_in  = 1'b0;
      o_deg_in    = '0;
      o_last_in   = 1'b1;

      case (state_ff)
         S_CLR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = STR_NONE;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_func;
               from_in = req_from;
               to_in   = req_to;
               str_in  = req_str;
               cap_in  = (int'(req_limit) > LIST_CAP) ? LIMIT_W'(LIST_CAP) : req_limit;
               j_in    = '0;
               cnt_in  = '0;
               k_in    = '0;
               mem_re  = 1'b1;
               // The first read goes out with the accept: the entry itself, or
               // entry zero of the row or column to scan.
               if ((req_func == FN_COL_DEG) || (req_func == FN_COL_LIST)) begin
                  mem_ra = {IDX_W'(0), IDX_W'(req_from)};
               end else if ((req_func == FN_ROW_DEG) || (req_func == FN_ROW_LIST)) begin
                  mem_ra = {IDX_W'(req_from), IDX_W'(0)};
               end else begin
                  mem_ra = {IDX_W'(req_from), IDX_W'(req_to)};
               end
               if (req_func inside {FN_READ, FN_WRITE}) begin
                  bad_in = req_bad_row || req_bad_col;
               end else begin
                  bad_in = req_bad_row;
               end
               if ((req_func inside {[FN_ROW_DEG:FN_COL_LIST]}) && !req_bad_row) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               case (func_ff)
                  FN_READ: begin
                     if (bad_ff) begin
                        o_status_in = ST_BAD_IDX;
                     end else begin
                        o_str_in = mem_rd_ff;
                     end
                  end
                  FN_WRITE: begin
                     if (bad_ff) begin
                        o_status_in = ST_BAD_IDX;
                     end else if (str_ff == STR_BAD) begin
                        o_status_in = ST_BAD_STR;
                     end else begin
                        // The entry was read in the accept cycle; nothing else can
                        // reach it before this write-back.
                        mem_we = 1'b1;
                        upd.en = 1'b1;
                     end
                  end
                  FN_ROW_DEG, FN_COL_DEG, FN_ROW_LIST, FN_COL_LIST: begin
                     o_status_in = ST_BAD_IDX;
                  end
                  default: begin
                     o_status_in = ST_OK;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // First pass: count the nonzero entries, one per cycle.
            if (!j_last) begin
               cnt_in = tot;
               j_in   = j_next;
               mem_re = 1'b1;
            end else if (out_free) begin
               if ((func_ff == FN_ROW_DEG) || (func_ff == FN_COL_DEG)) begin
                  out_load = 1'b1;
                  o_deg_in = tot;
                  state_in = S_IDLE;
               end else if (list_n == '0) begin
                  out_load = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  // Second pass lists list_n entries from the start again.
                  cnt_in   = list_n;
                  k_in     = '0;
                  j_in     = '0;
                  mem_re   = 1'b1;
                  mem_ra   = scan_row ? {from_i, IDX_W'(0)} : {IDX_W'(0), from_i};
                  state_in = S_LIST;
               end
            end
         end

         S_LIST: begin
            if (!entry_nz) begin
               j_in   = j_next;
               mem_re = 1'b1;
            end else if (out_free) begin
               out_load   = 1'b1;
               o_str_in   = mem_rd_ff;
               o_idx_in   = NODE_W'(j_ff);
               o_found_in = 1'b1;
               o_deg_in   = cnt_ff;
               o_last_in  = (DEGREE_W'(k_ff + DEGREE_W'(1)) == cnt_ff);
               if (o_last_in) begin
                  state_in = S_IDLE;
               end else begin
                  k_in   = k_ff + DEGREE_W'(1);
                  j_in   = j_next;
                  mem_re = 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      from_ff <= from_in;
      to_ff   <= to_in;
      str_ff  <= str_in;
      cap_ff  <= cap_in;
      bad_ff  <= bad_in;
      j_ff    <= j_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      if (out_load) begin
         o_status_ff <= o_status_in;
         o_str_ff    <= o_str_in;
         o_idx_ff    <= o_idx_in;
         o_found_ff  <= o_found_in;
         o_deg_ff    <= o_deg_in;
         o_last_ff   <= o_last_in;
         o_exc_ff    <= exc_count;
         o_inh_ff    <= inh_count;
         o_emp_ff    <= empty_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {o_emp_ff, o_inh_ff, o_exc_ff, o_deg_ff, o_idx_ff, o_str_ff,
                        o_status_ff};
   assign rsp_tuser  = o_found_ff;
   assign rsp_tlast  = o_last_ff;

   // A listed entry is never zero and always comes with a nonzero degree.
   a_found_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_found_ff) |-> (o_str_ff != STR_NONE) && (o_deg_ff != '0))
      else $error("listed result carries an empty entry or zero degree");

   // No result appears while the memory is being cleared.
   a_clr_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !rsp_valid_ff)
      else $error("result raised during clearing pass");

   // The list pass never emits more entries than it counted.
   a_list_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |-> (k_ff < cnt_ff))
      else $error("list pass ran past its count");

   // Memory writes in normal operation only come from a finished write request.
   a_write_src : assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff != S_CLR)) |-> (state_ff == S_EXEC) && (func_ff == FN_WRITE)
                                         && out_load)
      else $error("matrix written outside a write request");

endmodule
